>>> rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Shared widths, codes and defaults for the device slot table.
// ----------------------------------------------------------------------------
package dst_pkg;

	// default table depth
	localparam int SLOT_COUNT_DEF = 16;

	// field widths
	localparam int ID_W  = 48;
	localparam int MOD_W = 8;
	localparam int IDX_W = 4;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = ((ID_W + MOD_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((1 + IDX_W + 7) / 8) * 8;

	// one stored slot word: module number above identifier
	localparam int ENTRY_W = ID_W + MOD_W;

	// action codes
	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

>>> rtl/device_slot_table.sv
// ----------------------------------------------------------------------------
// device_slot_table
// Table of device slots with identifier lookup and first-free allocation.
// ----------------------------------------------------------------------------
// The slot scan reads one RAM entry per cycle through a single comparator and
// stops early when a matching slot is found. Input is held off while a scan
// runs and until its result is taken into the result register, so a new
// transaction is accepted only after the previous one is through.
// Reset: all slots inactive and read as identifier zero, via per-slot
// valid and active flops; no clearing pass, ready as soon as reset is released.
module device_slot_table #(
	parameter int SLOT_COUNT = dst_pkg::SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// device_id [47:0], module_number [55:48]
	input  logic [dst_pkg::IN_DATA_W-1:0] s_tdata,
	// action [0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// ok [0], slot_index [4:1], zero pad above
	output logic [dst_pkg::OUT_DATA_W-1:0] m_tdata
);

	import dst_pkg::*;

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

	state_t               state_q;
	logic                 action_q;
	logic [ID_W-1:0]      id_q;
	logic [MOD_W-1:0]     mod_q;
	logic [AW-1:0]        cnt_q;
	logic                 issue_q;
	logic                 pend_s1;
	logic [AW-1:0]        idx_s1;
	logic                 valid_s1;
	logic                 active_s1;
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [SLOT_COUNT-1:0] slot_active_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic                 in_fire;
	logic                 scan_end;
	logic                 out_free;
	logic                 commit;
	logic [ENTRY_W-1:0]   rd_entry;
	logic [ID_W-1:0]      rd_ident;
	logic                 match;
	logic                 hit;
	logic [AW-1:0]        hit_idx;
	logic                 free;
	logic [AW-1:0]        free_idx;
	logic                 res_ok;
	logic [AW-1:0]        res_slot;
	logic                 ram_we;

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == ST_DONE) && out_free;
	assign scan_end = (state_q == ST_SCAN) && pend_s1 && (match || idx_s1 == LAST_IDX);

	// slot identifier and module storage
	dst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (res_slot),
		.wdata ({mod_q, id_q}),
		.raddr (cnt_q),
		.rdata (rd_entry)
	);

	// slots never written read as identifier zero
	assign rd_ident = valid_s1 ? rd_entry[ID_W-1:0] : '0;

	dst_scan #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (in_fire),
		.cmp_en    (pend_s1),
		.cmp_idx   (idx_s1),
		.ident     (rd_ident),
		.active    (active_s1),
		.device_id (id_q),
		.match     (match),
		.hit       (hit),
		.hit_idx   (hit_idx),
		.free      (free),
		.free_idx  (free_idx)
	);

	// outcome of the scan, an add stores identifier and module in its slot
	always_comb begin
		res_ok   = 1'b0;
		res_slot = '0;
		if (hit) begin
			res_ok   = 1'b1;
			res_slot = hit_idx;
		end else if (action_q == ACT_ADD && free) begin
			res_ok   = 1'b1;
			res_slot = free_idx;
		end
		ram_we = commit && res_ok && (action_q == ACT_ADD);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
						issue_q <= 1'b1;
						pend_s1 <= 1'b0;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					pend_s1 <= issue_q;
					if (issue_q) begin
						if (cnt_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (scan_end) begin
						state_q <= ST_DONE;
						issue_q <= 1'b0;
						pend_s1 <= 1'b0;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input capture and per-read slot flags
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q <= s_tuser;
			id_q     <= s_tdata[ID_W-1:0];
			mod_q    <= s_tdata[ID_W+MOD_W-1:ID_W];
		end
		idx_s1    <= cnt_q;
		valid_s1  <= slot_valid_q[cnt_q];
		active_s1 <= slot_active_q[cnt_q];
	end

	// valid and active flags per slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q  <= '0;
			slot_active_q <= '0;
		end else if (commit && res_ok) begin
			if (ram_we) begin
				slot_valid_q[res_slot] <= 1'b1;
			end
			slot_active_q[res_slot] <= (action_q == ACT_ADD);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= OUT_DATA_W'({IDX_W'(res_slot), res_ok});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/dst_ram.sv
// ----------------------------------------------------------------------------
// dst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/dst_scan.sv
// ----------------------------------------------------------------------------
// dst_scan
// Shared identifier comparator with lowest-match and lowest-free tracking.
// ----------------------------------------------------------------------------
module dst_scan #(
	parameter int SLOT_COUNT = dst_pkg::SLOT_COUNT_DEF,
	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     cmp_en,
	input  logic [AW-1:0]            cmp_idx,
	input  logic [dst_pkg::ID_W-1:0] ident,
	input  logic                     active,
	input  logic [dst_pkg::ID_W-1:0] device_id,
	output logic                     match,
	output logic                     hit,
	output logic [AW-1:0]            hit_idx,
	output logic                     free,
	output logic [AW-1:0]            free_idx
);

	import dst_pkg::*;

	logic          hit_q;
	logic          free_q;
	logic [AW-1:0] hit_idx_q;
	logic [AW-1:0] free_idx_q;
	logic          free_now;

	// the one 48-bit compare, reused for every slot
	assign match    = cmp_en && !hit_q && (ident == device_id);
	assign free_now = cmp_en && !free_q && !active;

	// first hit and first free flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (clear) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (free_now) begin
				free_q <= 1'b1;
			end
		end
	end

	// slot numbers captured with the flags
	always_ff @(posedge clk) begin
		if (match) begin
			hit_idx_q <= cmp_idx;
		end
		if (free_now) begin
			free_idx_q <= cmp_idx;
		end
	end

	assign hit      = hit_q;
	assign hit_idx  = hit_idx_q;
	assign free     = free_q;
	assign free_idx = free_idx_q;

endmodule

>>> verif/device_slot_table_checker.sv
// ----------------------------------------------------------------------------
// device_slot_table_checker
// Watches both stream channels of the device slot table, keeps its own copy
// of the slot store and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module device_slot_table_checker #(
	parameter int SLOT_COUNT = dst_pkg::SLOT_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// device_id [47:0], module_number [55:48]
	input  logic [dst_pkg::IN_DATA_W-1:0]  s_tdata,
	// action [0]
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// ok [0], slot_index [4:1], zero pad above
	input  logic [dst_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                             errors,
	output int                             outstanding,
	output int                             checked,
	output int                             refused
);
	import dst_pkg::*;

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] slot;
	} lookup_result_t;

	// shadow copy of the slot store
	logic [ID_W-1:0]  tbl_ident  [SLOT_COUNT];
	logic [MOD_W-1:0] tbl_module [SLOT_COUNT];
	logic             tbl_active [SLOT_COUNT];

	lookup_result_t   lookup_results [$];

	// apply one add or delete to the shadow store and return its outcome
	function automatic lookup_result_t predict_access(
		input logic             act,
		input logic [ID_W-1:0]  id,
		input logic [MOD_W-1:0] mod
	);
		lookup_result_t res;
		int             hit;
		hit = -1;
		// lowest slot with the same identifier, active flag ignored
		for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
			if (tbl_ident[s] == id) hit = s;
		end
		// no match on add: fall back to the lowest inactive slot
		if (act == ACT_ADD && hit < 0) begin
			for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
				if (!tbl_active[s]) hit = s;
			end
			if (hit >= 0) tbl_ident[hit] = id;
		end
		if (hit >= 0) begin
			if (act == ACT_ADD) begin
				tbl_module[hit] = mod;
				tbl_active[hit] = 1'b1;
			end else begin
				tbl_active[hit] = 1'b0;
			end
		end
		res.ok   = (hit >= 0);
		res.slot = (hit >= 0) ? hit[IDX_W-1:0] : '0;
		return res;
	endfunction

	// result side first so a result never pairs with the transaction it shares an edge with
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		lookup_result_t got;
		lookup_result_t pred;
		if (!arst_n) begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				tbl_ident[s]  = '0;
				tbl_module[s] = '0;
				tbl_active[s] = 1'b0;
			end
			lookup_results.delete();
			errors      = 0;
			checked     = 0;
			refused     = 0;
			outstanding = 0;
		end else begin
			// compare an accepted result with the oldest prediction
			if (m_tvalid && m_tready) begin
				got.ok   = m_tdata[0];
				got.slot = m_tdata[IDX_W:1];
				checked++;
				if (!got.ok) refused++;
				if (lookup_results.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result ok %0b slot %0d",
							$realtime, got.ok, got.slot);
					errors++;
				end else begin
					want = lookup_results.pop_front();
					if (got.ok !== want.ok || got.slot !== want.slot) begin
						if (errors < 10)
							$display("%0t: result mismatch ok exp %0b got %0b, slot exp %0d got %0d",
								$realtime, want.ok, got.ok, want.slot, got.slot);
						errors++;
					end
				end
			end
			// predict on every accepted input transaction
			if (s_tvalid && s_tready) begin
				pred = predict_access(s_tuser, s_tdata[ID_W-1:0],
					s_tdata[ID_W+MOD_W-1:ID_W]);
				lookup_results = {lookup_results, pred};
			end
			outstanding = lookup_results.size();
		end
	end

endmodule

>>> verif/device_slot_table_tb.sv
// ----------------------------------------------------------------------------
// device_slot_table_tb
// Drives adds and deletes into the device slot table: a directed pass over
// zero and all-ones identifiers, a full table, refresh and reuse of a freed
// slot, then random traffic on a small identifier pool with random idling on
// both channels and one long output stall.
// ----------------------------------------------------------------------------
module device_slot_table_tb;
	import dst_pkg::*;

	localparam int SLOTS        = SLOT_COUNT_DEF;
	localparam int RANDOM_ITEMS = 1000;
	localparam int QUIET_ITEMS  = 150;
	localparam int HOLD_AT      = 400;
	localparam int LONG_HOLD    = 300;
	localparam int POOL_SIZE    = 20;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = ACT_ADD;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	int errors;
	int outstanding;
	int checked;
	int refused;

	bit quiet_tail   = 1'b0;
	bit hold_request = 1'b0;
	bit hold_done    = 1'b0;
	int adds_sent    = 0;
	int deletes_sent = 0;

	logic [ID_W-1:0] id_pool [POOL_SIZE];

	device_slot_table #(
		.SLOT_COUNT(SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	device_slot_table_checker #(
		.SLOT_COUNT(SLOTS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.errors     (errors),
		.outstanding(outstanding),
		.checked    (checked),
		.refused    (refused)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#3000000;
		$display("device_slot_table_tb: FAIL");
		$finish;
	end

	// offer one transaction, wait for acceptance, maybe go idle for a burst
	task automatic send_item(
		input logic             act,
		input logic [ID_W-1:0]  id,
		input logic [MOD_W-1:0] mod
	);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {mod, id};
		do @(posedge clk); while (!s_tready);
		if (act == ACT_ADD) adds_sent++;
		else deletes_sent++;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// result receiver: random stall bursts, one long hold-off, none at the tail
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (quiet_tail || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
				repeat (quiet_tail ? 1 : $urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		int              j;
		int              add_pct;
		logic            act;
		logic [ID_W-1:0] fill_id;

		// identifier pool, extremes included
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++) id_pool[k] = ID_W'({$urandom, $urandom});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// delete of zero hits the never-written slot 0 while inactive
		send_item(ACT_DELETE, '0, 8'h5a);
		send_item(ACT_ADD, '0, 8'hff);
		send_item(ACT_ADD, '1, 8'h00);
		// unknown identifier on delete
		send_item(ACT_DELETE, 48'h0000_1234_5678, 8'h00);
		// fill every remaining slot
		for (int k = 2; k < SLOTS; k++) begin
			fill_id = 48'h5a5a_0000_0000 | ID_W'(k);
			send_item(ACT_ADD, fill_id, MOD_W'(k));
		end
		// table full, then a refresh still succeeds
		send_item(ACT_ADD, 48'h0000_0000_beef, 8'h11);
		send_item(ACT_ADD, '1, 8'h22);
		// freed slot is reused by the next new identifier
		send_item(ACT_DELETE, 48'h5a5a_0000_0007, 8'h00);
		send_item(ACT_ADD, 48'h0000_0000_beef, 8'h33);
		// second delete of the same identifier matches an inactive slot
		send_item(ACT_DELETE, '1, 8'hff);
		send_item(ACT_DELETE, '1, 8'h00);
		send_item(ACT_DELETE, '0, 8'h00);

		// random traffic, add-heavy and delete-heavy stretches alternate
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_AT) hold_request = 1'b1;
			if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
			add_pct = ((n / 100) % 2 == 0) ? 75 : 35;
			j = $urandom_range(0, POOL_SIZE - 1);
			if ($urandom_range(0, 99) < 8) begin
				// retire the old identifier so no slot is left orphaned
				send_item(ACT_DELETE, id_pool[j], MOD_W'($urandom));
				id_pool[j] = ID_W'({$urandom, $urandom});
			end
			act = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_DELETE;
			send_item(act, id_pool[j], MOD_W'($urandom));
		end
		s_tvalid <= 1'b0;

		// drain, then allow one worst-case scan more
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (SLOTS + 4) @(posedge clk);

		$display("device_slot_table_tb: %0d adds and %0d deletes sent, %0d results checked",
			adds_sent, deletes_sent, checked);
		$display("device_slot_table_tb: %0d refused (table full or unknown id), %0d mismatches",
			refused, errors);
		if (errors == 0) begin
			$display("device_slot_table_tb: PASS");
		end else begin
			$display("device_slot_table_tb: FAIL");
		end
		$finish;
	end

endmodule
